FILE: rtl/core/sia_pkg.sv
// Shared types and codes for the signed integer ALU.
// No dependencies; every other file of the block imports this package.
package sia_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int CMD_W          = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD = 4'd0,
    CMD_SUB = 4'd1,
    CMD_MUL = 4'd2,
    CMD_DIV = 4'd3,
    CMD_AND = 4'd4,
    CMD_OR  = 4'd5,
    CMD_XOR = 4'd6,
    CMD_NOT = 4'd7,
    CMD_SHL = 4'd8,
    CMD_SAR = 4'd9
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OVF   = 2'd1,
    ST_DIV0  = 2'd2,
    ST_SHIFT = 2'd3
  } status_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    status_t          st;
    logic             lt;
    logic             eq;
    logic             neg;
  } ctl_t;

endpackage

FILE: rtl/core/sia_if.sv
// Valid/ready channel interfaces for the signed integer ALU.
// Depends on sia_pkg for the opcode and status types.
interface sia_in_if import sia_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic [CMD_W-1:0]             cmd;
  logic signed [DATA_WIDTH-1:0] operand_a;
  logic signed [DATA_WIDTH-1:0] operand_b;

  modport source (output valid, cmd, operand_a, operand_b, input ready);
  modport sink (input valid, cmd, operand_a, operand_b, output ready);
endinterface

interface sia_out_if import sia_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] result;
  logic [1:0]                   status;
  logic                         less_than;
  logic                         equal;

  modport source (output valid, result, status, less_than, equal, input ready);
  modport sink (input valid, result, status, less_than, equal, output ready);
endinterface

FILE: rtl/core/sia_front.sv
// First stage: decode, logic/add/shift results, compare flags, multiply, divide setup.
// Depends on sia_pkg.
module sia_front import sia_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_v,
  input  logic [CMD_W-1:0]             cmd,
  input  logic signed [DATA_WIDTH-1:0] a,
  input  logic signed [DATA_WIDTH-1:0] b,
  output logic                         v_r,
  output ctl_t                         ctl_r,
  output logic [DATA_WIDTH-1:0]        res_r,
  output logic [2*DATA_WIDTH-1:0]      prod_r,
  output logic [DATA_WIDTH-1:0]        dvd_r,
  output logic [DATA_WIDTH-1:0]        dvs_r
);
  localparam int SW = $clog2(DATA_WIDTH);
  localparam logic [DATA_WIDTH-1:0] TOP = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic [DATA_WIDTH-1:0] SH_MAX = DATA_WIDTH'(DATA_WIDTH - 2);

  logic [DATA_WIDTH-1:0]   ua, ub, sum, dif, res_nxt;
  logic [2*DATA_WIDTH-1:0] prod_nxt;
  logic                    a_min, b_min, sh_ok;
  ctl_t                    ctl_nxt;

  always_comb begin
    ua    = a[DATA_WIDTH-1] ? (~a + 1'b1) : a;
    ub    = b[DATA_WIDTH-1] ? (~b + 1'b1) : b;
    a_min = (a == TOP);
    b_min = (b == TOP);
    sum   = a + b;
    dif   = a - b;
    sh_ok = !b[DATA_WIDTH-1] && (b <= SH_MAX);
    prod_nxt = (2*DATA_WIDTH)'(ua) * (2*DATA_WIDTH)'(ub);
    res_nxt  = '0;
    ctl_nxt.cmd = cmd;
    ctl_nxt.st  = ST_OK;
    ctl_nxt.lt  = (a < b);
    ctl_nxt.eq  = (a == b);
    ctl_nxt.neg = a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
    case (cmd)
      CMD_ADD: begin
        if (((a ^ sum) & (b ^ sum) & TOP) != '0) ctl_nxt.st = ST_OVF;
        else res_nxt = sum;
      end
      CMD_SUB: begin
        if (b_min || (((a ^ b) & (a ^ dif) & TOP) != '0)) ctl_nxt.st = ST_OVF;
        else res_nxt = dif;
      end
      CMD_MUL: begin
        if (a_min || b_min) ctl_nxt.st = ST_OVF;
      end
      CMD_DIV: begin
        if (b == '0) ctl_nxt.st = ST_DIV0;
        else if (a_min || b_min) ctl_nxt.st = ST_OVF;
      end
      CMD_AND: res_nxt = a & b;
      CMD_OR:  res_nxt = a | b;
      CMD_XOR: res_nxt = a ^ b;
      CMD_NOT: res_nxt = ~a;
      CMD_SHL: begin
        if (!sh_ok) ctl_nxt.st = ST_SHIFT;
        else res_nxt = a << b[SW-1:0];
      end
      CMD_SAR: begin
        if (!sh_ok) ctl_nxt.st = ST_SHIFT;
        else res_nxt = a >>> b[SW-1:0];
      end
      default: res_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r  <= ctl_nxt;
      res_r  <= res_nxt;
      prod_r <= prod_nxt;
      dvd_r  <= ua;
      dvs_r  <= ub;
    end
  end
endmodule

FILE: rtl/core/sia_mfix.sv
// Second stage: multiply range check and sign, divider register setup.
// Depends on sia_pkg.
module sia_mfix import sia_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    v,
  input  ctl_t                    ctl,
  input  logic [DATA_WIDTH-1:0]   res,
  input  logic [2*DATA_WIDTH-1:0] prod,
  input  logic [DATA_WIDTH-1:0]   dvd,
  input  logic [DATA_WIDTH-1:0]   dvs,
  output logic                    v_r,
  output ctl_t                    ctl_r,
  output logic [DATA_WIDTH-1:0]   res_r,
  output logic [DATA_WIDTH-1:0]   rem_r,
  output logic [DATA_WIDTH-1:0]   quo_r,
  output logic [DATA_WIDTH-1:0]   dvs_r
);
  localparam logic [2*DATA_WIDTH-1:0] LIM_NEG = (2*DATA_WIDTH)'(1) << (DATA_WIDTH - 1);
  localparam logic [2*DATA_WIDTH-1:0] LIM_POS = LIM_NEG - 1'b1;

  ctl_t                  ctl_nxt;
  logic [DATA_WIDTH-1:0] res_nxt;

  always_comb begin
    ctl_nxt = ctl;
    res_nxt = res;
    if ((ctl.cmd == CMD_MUL) && (ctl.st == ST_OK)) begin
      if (prod > (ctl.neg ? LIM_NEG : LIM_POS)) begin
        ctl_nxt.st = ST_OVF;
        res_nxt    = '0;
      end else begin
        res_nxt = ctl.neg ? (~prod[DATA_WIDTH-1:0] + 1'b1) : prod[DATA_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r <= ctl_nxt;
      res_r <= res_nxt;
      rem_r <= '0;
      quo_r <= dvd;
      dvs_r <= dvs;
    end
  end
endmodule

FILE: rtl/core/sia_div_stage.sv
// One restoring-division stage: one quotient bit per stage, carries the item along.
// Depends on sia_pkg.
module sia_div_stage import sia_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  v,
  input  ctl_t                  ctl,
  input  logic [DATA_WIDTH-1:0] res,
  input  logic [DATA_WIDTH-1:0] rem,
  input  logic [DATA_WIDTH-1:0] quo,
  input  logic [DATA_WIDTH-1:0] dvs,
  output logic                  v_r,
  output ctl_t                  ctl_r,
  output logic [DATA_WIDTH-1:0] res_r,
  output logic [DATA_WIDTH-1:0] rem_r,
  output logic [DATA_WIDTH-1:0] quo_r,
  output logic [DATA_WIDTH-1:0] dvs_r
);
  logic [DATA_WIDTH-1:0] sh;
  logic [DATA_WIDTH:0]   trial;
  logic                  qbit;

  always_comb begin
    sh    = {rem[DATA_WIDTH-2:0], quo[DATA_WIDTH-1]};
    trial = {1'b0, sh} - {1'b0, dvs};
    qbit  = !trial[DATA_WIDTH];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r <= ctl;
      res_r <= res;
      rem_r <= qbit ? trial[DATA_WIDTH-1:0] : sh;
      quo_r <= {quo[DATA_WIDTH-2:0], qbit};
      dvs_r <= dvs;
    end
  end
endmodule

FILE: rtl/core/sia_back.sv
// Last stage: quotient sign, result select and a two-entry output queue.
// Depends on sia_pkg.
module sia_back import sia_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  v,
  input  ctl_t                  ctl,
  input  logic [DATA_WIDTH-1:0] res,
  input  logic [DATA_WIDTH-1:0] quo,
  output logic                  en,
  output logic                  spare_v,
  output logic                  out_v,
  input  logic                  out_rdy,
  output logic [DATA_WIDTH-1:0] out_res,
  output status_t               out_st,
  output logic                  out_lt,
  output logic                  out_eq
);
  typedef struct packed {
    logic [DATA_WIDTH-1:0] res;
    status_t               st;
    logic                  lt;
    logic                  eq;
  } ent_t;

  ent_t head_r, head_nxt, spare_r, spare_nxt, fin;
  logic head_v_r, head_v_nxt, spare_v_r, spare_v_nxt, push, pop;

  always_comb begin
    fin.res = res;
    if ((ctl.cmd == CMD_DIV) && (ctl.st == ST_OK)) begin
      fin.res = ctl.neg ? (~quo + 1'b1) : quo;
    end
    fin.st = ctl.st;
    fin.lt = ctl.lt;
    fin.eq = ctl.eq;
  end

  always_comb begin
    en          = !spare_v_r;
    push        = en && v;
    pop         = head_v_r && out_rdy;
    head_nxt    = head_r;
    head_v_nxt  = head_v_r;
    spare_nxt   = spare_r;
    spare_v_nxt = spare_v_r;
    if (pop) begin
      if (spare_v_r) begin
        head_nxt    = spare_r;
        spare_v_nxt = 1'b0;
      end else begin
        head_nxt   = fin;
        head_v_nxt = push;
      end
    end else if (push) begin
      if (!head_v_r) begin
        head_nxt   = fin;
        head_v_nxt = 1'b1;
      end else begin
        spare_nxt   = fin;
        spare_v_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r  <= 1'b0;
      spare_v_r <= 1'b0;
    end else begin
      head_v_r  <= head_v_nxt;
      spare_v_r <= spare_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r  <= head_nxt;
    spare_r <= spare_nxt;
  end

  assign spare_v = spare_v_r;
  assign out_v   = head_v_r;
  assign out_res = head_r.res;
  assign out_st  = head_r.st;
  assign out_lt  = head_r.lt;
  assign out_eq  = head_r.eq;
endmodule

FILE: rtl/core/signed_integer_alu_unit.sv
// Top level of the signed integer ALU: front stage, multiply check, divider chain, output.
// Depends on sia_pkg, sia_if, sia_front, sia_mfix, sia_div_stage and sia_back.
//
// Pipelined signed ALU: add, sub, mul, div (toward zero), and, or, xor, not, shl, sar,
// with status (ok, overflow, divide by zero, bad shift) and signed less-than/equal flags.
// One operation is taken per cycle unless the input stalls; results leave in order. The
// divider forms one quotient bit per pipeline stage, and every operation passes through
// the same stages. A two-entry output queue keeps the input open while one result waits;
// the input stalls only when both entries are full.
module signed_integer_alu_unit import sia_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input logic    clk,
  input logic    rst_n,
  sia_in_if.sink   in_ch,
  sia_out_if.source out_ch
);
  logic                    en, spare_v, fv;
  ctl_t                    fctl;
  logic [DATA_WIDTH-1:0]   fres, fdvd, fdvs;
  logic [2*DATA_WIDTH-1:0] fprod;
  status_t                 out_st;

  logic                  dv   [0:DATA_WIDTH];
  ctl_t                  dctl [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] dres [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] drem [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] dquo [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] ddvs [0:DATA_WIDTH];

  assign in_ch.ready = en;

  sia_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .clk(clk), .rst_n(rst_n), .en(en), .in_v(in_ch.valid), .cmd(in_ch.cmd),
    .a(in_ch.operand_a), .b(in_ch.operand_b), .v_r(fv), .ctl_r(fctl), .res_r(fres),
    .prod_r(fprod), .dvd_r(fdvd), .dvs_r(fdvs)
  );

  sia_mfix #(.DATA_WIDTH(DATA_WIDTH)) u_mfix (
    .clk(clk), .rst_n(rst_n), .en(en), .v(fv), .ctl(fctl), .res(fres), .prod(fprod),
    .dvd(fdvd), .dvs(fdvs), .v_r(dv[0]), .ctl_r(dctl[0]), .res_r(dres[0]),
    .rem_r(drem[0]), .quo_r(dquo[0]), .dvs_r(ddvs[0])
  );

  for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_div
    sia_div_stage #(.DATA_WIDTH(DATA_WIDTH)) u_stage (
      .clk(clk), .rst_n(rst_n), .en(en), .v(dv[k]), .ctl(dctl[k]), .res(dres[k]),
      .rem(drem[k]), .quo(dquo[k]), .dvs(ddvs[k]), .v_r(dv[k+1]), .ctl_r(dctl[k+1]),
      .res_r(dres[k+1]), .rem_r(drem[k+1]), .quo_r(dquo[k+1]), .dvs_r(ddvs[k+1])
    );
  end

  sia_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
    .clk(clk), .rst_n(rst_n), .v(dv[DATA_WIDTH]), .ctl(dctl[DATA_WIDTH]),
    .res(dres[DATA_WIDTH]), .quo(dquo[DATA_WIDTH]), .en(en), .spare_v(spare_v),
    .out_v(out_ch.valid), .out_rdy(out_ch.ready), .out_res(out_ch.result),
    .out_st(out_st), .out_lt(out_ch.less_than), .out_eq(out_ch.equal)
  );

  assign out_ch.status = out_st;

`ifndef NO_ASSERTIONS
  a_spare_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    spare_v |-> out_ch.valid)
    else $error("queue spare entry held without head entry");

  a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_st != ST_OK)) |-> (out_ch.result == '0))
    else $error("nonzero result with error status");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.equal) |-> !out_ch.less_than)
    else $error("equal and less_than both set");
`endif
endmodule
